>>> design/sukt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sukt_pkg: shared types and constants of the sorted unique key table
// Command and status codes, field widths and the compare result bundle.
// ----------------------------------------------------------------------------
package sukt_pkg;

    // field widths of the item and the result
    localparam int KEY_W     = 32;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 3;
    localparam int ENTRY_W   = 5;
    localparam int M_TDATA_W = 40;
    localparam int M_PAD_W   = M_TDATA_W - KEY_W - ENTRY_W;

    // default table size
    localparam int DEFAULT_CAPACITY = 16;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_DUMP   = 2'd3
    } cmd_t;

    // status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_DUP     = 3'd1,
        ST_MISSING = 3'd2,
        ST_FULL    = 3'd3,
        ST_EMPTY   = 3'd4
    } status_t;

    // shared comparator result: stored key against probe key
    typedef struct packed {
        logic eq;
        logic gt;
    } cmp_res_t;

endpackage
`default_nettype wire

>>> design/sorted_unique_key_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_unique_key_table: ordered set of distinct signed keys
// Insert, delete, search and dump over a sorted table of up to CAPACITY keys.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                              | tuser       | tlast
//  --------+-----+------------------------------------+-------------+-----------
//  s_      | in  | [31:0] key                         | [1:0] cmd   | -
//  m_      | out | [31:0] key_out, [36:32] entry_count| [2:0] status| last
//
//  one item at a time; s_tready is high only while the sequencer is idle
//  a shared comparator walks the table one entry at a time, a read step then a compare step
//  insert/delete shift entries one at a time (read, write) through the single write port
//  reset empties the table at once; no clearing pass, stalls on m_ just wait
//
module sorted_unique_key_table #(
    parameter int CAPACITY = sukt_pkg::DEFAULT_CAPACITY
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [sukt_pkg::KEY_W-1:0]        s_tdata,   // [31:0] key
    input  wire logic [sukt_pkg::CMD_W-1:0]        s_tuser,   // [1:0] cmd
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [sukt_pkg::M_TDATA_W-1:0]    m_tdata,   // [31:0] key_out, [36:32] entry_count
    output logic      [sukt_pkg::STATUS_W-1:0]     m_tuser,   // [2:0] status
    output logic                                   m_tlast
);
    import sukt_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    typedef enum logic [9:0] {
        S_IDLE      = 10'b00_0000_0001,
        S_SCAN_RD   = 10'b00_0000_0010,
        S_SCAN_CMP  = 10'b00_0000_0100,
        S_DECIDE    = 10'b00_0000_1000,
        S_MOVE_RD   = 10'b00_0001_0000,
        S_MOVE_WR   = 10'b00_0010_0000,
        S_PUT       = 10'b00_0100_0000,
        S_DUMP_RD   = 10'b00_1000_0000,
        S_DUMP_EMIT = 10'b01_0000_0000,
        S_OUT       = 10'b10_0000_0000
    } state_t;

    typedef struct packed {
        status_t            status;
        logic [KEY_W-1:0]   key;
        logic [ENTRY_W-1:0] count;
        logic               last;
    } res_t;

    function automatic res_t make_res(status_t st, logic [KEY_W-1:0] k,
                                      logic [CNT_W-1:0] c, logic l);
        res_t r;
        r.status = st;
        r.key    = k;
        r.count  = ENTRY_W'(c);
        r.last   = l;
        return r;
    endfunction

    state_t             state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic               found_reg, found_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               out_valid_reg, out_valid_next;
    res_t               out_reg, out_next;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [KEY_W-1:0]   wr_data;
    logic [IDX_W-1:0]   rd_addr;
    logic [KEY_W-1:0]   rd_data;
    cmp_res_t           cmp;

    logic [CNT_W-1:0]   idx_ext;
    logic [CNT_W-1:0]   count_dec;

    // key storage
    sukt_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // shared comparator
    sukt_cmp u_cmp (
        .stored_key (rd_data),
        .probe_key  (key_reg),
        .res        (cmp)
    );

    assign idx_ext   = CNT_W'(idx_reg);
    assign count_dec = count_reg - CNT_ONE;

    // handshake and result port
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_reg.count, out_reg.key};
    assign m_tuser  = out_reg.status;
    assign m_tlast  = out_reg.last;

    // sequencer
    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        found_next     = found_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = rd_data;
        rd_addr        = idx_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = cmd_t'(s_tuser);
                    key_next   = s_tdata;
                    idx_next   = '0;
                    pos_next   = '0;
                    found_next = 1'b0;
                    if (cmd_t'(s_tuser) == CMD_DUMP) begin
                        if (count_reg == '0) begin
                            out_valid_next = 1'b1;
                            out_next       = make_res(ST_EMPTY, s_tdata, count_reg, 1'b1);
                            state_next     = S_OUT;
                        end else begin
                            state_next = S_DUMP_RD;
                        end
                    end else if (count_reg == '0) begin
                        state_next = S_DECIDE;
                    end else begin
                        state_next = S_SCAN_RD;
                    end
                end
            end

            // read one entry for the compare
            S_SCAN_RD: begin
                state_next = S_SCAN_CMP;
            end

            // compare: stop on match, on a larger key, or at the end
            S_SCAN_CMP: begin
                if (cmp.eq) begin
                    found_next = 1'b1;
                    pos_next   = idx_ext;
                    state_next = S_DECIDE;
                end else if (cmp.gt) begin
                    pos_next   = idx_ext;
                    state_next = S_DECIDE;
                end else if (idx_ext == count_dec) begin
                    pos_next   = count_reg;
                    state_next = S_DECIDE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end

            // act on the scan outcome
            S_DECIDE: begin
                unique case (cmd_reg)
                    CMD_INSERT: begin
                        if (found_reg) begin
                            out_valid_next = 1'b1;
                            out_next       = make_res(ST_DUP, key_reg, count_reg, 1'b1);
                            state_next     = S_OUT;
                        end else if (count_reg == CNT_FULL) begin
                            out_valid_next = 1'b1;
                            out_next       = make_res(ST_FULL, key_reg, count_reg, 1'b1);
                            state_next     = S_OUT;
                        end else if (pos_reg == count_reg) begin
                            state_next = S_PUT;
                        end else begin
                            idx_next   = IDX_W'(count_reg);
                            state_next = S_MOVE_RD;
                        end
                    end
                    CMD_DELETE: begin
                        if (!found_reg) begin
                            out_valid_next = 1'b1;
                            out_next       = make_res(ST_MISSING, key_reg, count_reg, 1'b1);
                            state_next     = S_OUT;
                        end else if (pos_reg == count_dec) begin
                            count_next     = count_dec;
                            out_valid_next = 1'b1;
                            out_next       = make_res(ST_OK, key_reg, count_dec, 1'b1);
                            state_next     = S_OUT;
                        end else begin
                            idx_next   = IDX_W'(pos_reg);
                            state_next = S_MOVE_RD;
                        end
                    end
                    CMD_SEARCH: begin
                        out_valid_next = 1'b1;
                        state_next     = S_OUT;
                        if (count_reg == '0) begin
                            out_next = make_res(ST_EMPTY, key_reg, count_reg, 1'b1);
                        end else if (!found_reg) begin
                            out_next = make_res(ST_MISSING, key_reg, count_reg, 1'b1);
                        end else begin
                            out_next = make_res(ST_OK, key_reg, count_reg, 1'b1);
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            // fetch the neighbor that moves into idx
            S_MOVE_RD: begin
                if (cmd_reg == CMD_INSERT) begin
                    rd_addr = idx_reg - 1'b1;
                end else begin
                    rd_addr = idx_reg + 1'b1;
                end
                state_next = S_MOVE_WR;
            end

            // write the moved key, step toward the gap on insert, toward the end on delete
            S_MOVE_WR: begin
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = rd_data;
                if (cmd_reg == CMD_INSERT) begin
                    idx_next = idx_reg - 1'b1;
                    if (CNT_W'(idx_reg - 1'b1) == pos_reg) begin
                        state_next = S_PUT;
                    end else begin
                        state_next = S_MOVE_RD;
                    end
                end else begin
                    idx_next = idx_reg + 1'b1;
                    if ((idx_ext + CNT_ONE) == count_dec) begin
                        count_next     = count_dec;
                        out_valid_next = 1'b1;
                        out_next       = make_res(ST_OK, key_reg, count_dec, 1'b1);
                        state_next     = S_OUT;
                    end else begin
                        state_next = S_MOVE_RD;
                    end
                end
            end

            // place the new key in its slot
            S_PUT: begin
                wr_en          = 1'b1;
                wr_addr        = IDX_W'(pos_reg);
                wr_data        = key_reg;
                count_next     = count_reg + CNT_ONE;
                out_valid_next = 1'b1;
                out_next       = make_res(ST_OK, key_reg, count_reg + CNT_ONE, 1'b1);
                state_next     = S_OUT;
            end

            // dump: read one key
            S_DUMP_RD: begin
                state_next = S_DUMP_EMIT;
            end

            S_DUMP_EMIT: begin
                out_valid_next = 1'b1;
                out_next       = make_res(ST_OK, rd_data, count_reg, idx_ext == count_dec);
                state_next     = S_OUT;
            end

            // hold the result item until taken
            S_OUT: begin
                if (m_tready) begin
                    out_valid_next = 1'b0;
                    if (cmd_reg == CMD_DUMP && !out_reg.last) begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_DUMP_RD;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        key_reg   <= key_next;
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        found_reg <= found_next;
        out_reg   <= out_next;
    end

endmodule
`default_nettype wire

>>> design/sukt_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sukt_store: key storage
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module sukt_store #(
    parameter int CAPACITY = sukt_pkg::DEFAULT_CAPACITY
) (
    input  wire logic                                  aclk,
    input  wire logic                                  wr_en,
    input  wire logic [$clog2(CAPACITY)-1:0]           wr_addr,
    input  wire logic [sukt_pkg::KEY_W-1:0]            wr_data,
    input  wire logic [$clog2(CAPACITY)-1:0]           rd_addr,
    output logic      [sukt_pkg::KEY_W-1:0]            rd_data
);
    import sukt_pkg::*;

    logic [KEY_W-1:0] mem [CAPACITY];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

>>> design/sukt_cmp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sukt_cmp: shared key comparator
// Signed compare of a stored key against the probe key.
// ----------------------------------------------------------------------------
module sukt_cmp (
    input  wire logic [sukt_pkg::KEY_W-1:0] stored_key,
    input  wire logic [sukt_pkg::KEY_W-1:0] probe_key,
    output sukt_pkg::cmp_res_t              res
);
    import sukt_pkg::*;

    // equality and signed greater-than
    always_comb begin
        res.eq = (stored_key == probe_key);
        res.gt = ($signed(stored_key) > $signed(probe_key));
    end

endmodule
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the sorted unique key table
// A directed walk through empty, full, duplicate and missing-key cases is
// followed by random command runs under several idle and stall patterns.
// Every item goes through a local model of the table, and each result is
// compared field by field, in order, with the model's replies or a typed row's own.
// ----------------------------------------------------------------------------
module tb;
    import sukt_pkg::*;

    localparam int CAP              = DEFAULT_CAPACITY;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int TAIL_CYCLES      = 100;
    localparam int RANDOM_PER_PHASE = 75;

    // one result as the model sees it
    typedef struct packed {
        status_t             status;
        logic [KEY_W-1:0]    key;
        logic [ENTRY_W-1:0]  count;
        logic                last;
    } reply_t;

    // one row of the directed plan; typed rows carry their own single reply
    typedef struct packed {
        cmd_t                cmd;
        logic [KEY_W-1:0]    key;
        logic [ENTRY_W-1:0]  reps;
        logic                typed;
        status_t             status;
        logic [ENTRY_W-1:0]  count;
    } plan_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [KEY_W-1:0]       s_tdata;    // [31:0] key
    logic [CMD_W-1:0]       s_tuser;    // [1:0] cmd
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;    // [31:0] key_out, [36:32] entry_count
    logic [STATUS_W-1:0]    m_tuser;    // [2:0] status
    logic                   m_tlast;

    // model of the table contents
    logic signed [KEY_W-1:0] held [CAP];
    int                      held_n;

    reply_t    replies_due [$];
    reply_t    fresh [$];
    plan_row_t plan [$];
    reply_t    want;
    int        fails;
    int        cycles;
    int        idle_pct;
    int        stall_pct;

    sorted_unique_key_table #(
        .CAPACITY (CAP)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // receiver back-pressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // compare each accepted result with the oldest predicted reply
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (replies_due.size() == 0) begin
                $error("unexpected result: status %0d key_out %0h entry_count %0d last %0b",
                       m_tuser, m_tdata[KEY_W-1:0], m_tdata[KEY_W +: ENTRY_W], m_tlast);
                fails++;
            end else begin
                want = replies_due.pop_front();
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    fails++;
                end
                if (m_tdata[KEY_W-1:0] !== want.key) begin
                    $error("key_out: expected %0h, got %0h", want.key, m_tdata[KEY_W-1:0]);
                    fails++;
                end
                if (m_tdata[KEY_W +: ENTRY_W] !== want.count) begin
                    $error("entry_count: expected %0d, got %0d",
                           want.count, m_tdata[KEY_W +: ENTRY_W]);
                    fails++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, m_tlast);
                    fails++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic reply_t reply_of(status_t st, logic [KEY_W-1:0] k, int n, logic fin);
        reply_t r;
        r.status = st;
        r.key    = k;
        r.count  = n[ENTRY_W-1:0];
        r.last   = fin;
        return r;
    endfunction

    function automatic plan_row_t cmd_row(cmd_t c, logic [KEY_W-1:0] k, int reps,
                                          logic typed, status_t st, int n);
        plan_row_t p;
        p.cmd    = c;
        p.key    = k;
        p.reps   = reps[ENTRY_W-1:0];
        p.typed  = typed;
        p.status = st;
        p.count  = n[ENTRY_W-1:0];
        return p;
    endfunction

    // apply one command to the table model, leaving its replies in fresh
    function automatic void table_apply(cmd_t c, logic signed [KEY_W-1:0] k);
        int hit;
        int p;
        int i;
        hit = -1;
        fresh.delete();
        for (i = 0; i < held_n; i++) begin
            if (held[i] == k) hit = i;
        end
        case (c)
            CMD_INSERT: begin
                // duplicate wins over full
                if (hit >= 0) begin
                    fresh.push_back(reply_of(ST_DUP, k, held_n, 1'b1));
                end else if (held_n >= CAP) begin
                    fresh.push_back(reply_of(ST_FULL, k, held_n, 1'b1));
                end else begin
                    p = 0;
                    while (p < held_n && held[p] < k) p++;
                    for (i = held_n; i > p; i--) held[i] = held[i-1];
                    held[p] = k;
                    held_n++;
                    fresh.push_back(reply_of(ST_OK, k, held_n, 1'b1));
                end
            end
            CMD_DELETE: begin
                if (hit < 0) begin
                    fresh.push_back(reply_of(ST_MISSING, k, held_n, 1'b1));
                end else begin
                    for (i = hit; i + 1 < held_n; i++) held[i] = held[i+1];
                    held_n--;
                    fresh.push_back(reply_of(ST_OK, k, held_n, 1'b1));
                end
            end
            CMD_SEARCH: begin
                if (held_n == 0) begin
                    fresh.push_back(reply_of(ST_EMPTY, k, held_n, 1'b1));
                end else if (hit < 0) begin
                    fresh.push_back(reply_of(ST_MISSING, k, held_n, 1'b1));
                end else begin
                    fresh.push_back(reply_of(ST_OK, held[hit], held_n, 1'b1));
                end
            end
            CMD_DUMP: begin
                // empty dump echoes the input key
                if (held_n == 0) begin
                    fresh.push_back(reply_of(ST_EMPTY, k, held_n, 1'b1));
                end else begin
                    for (i = 0; i < held_n; i++) begin
                        fresh.push_back(reply_of(ST_OK, held[i], held_n, i + 1 == held_n));
                    end
                end
            end
        endcase
    endfunction

    // key mix: held keys, a narrow band around zero, extremes, full range
    function automatic logic [KEY_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (held_n > 0 && sel < 3) return held[$urandom_range(0, held_n - 1)];
        case (sel)
            3: return $urandom();
            4: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom_range(0, 47) - 24;
        endcase
    endfunction

    // send one item, starting and ending on a falling edge
    task automatic issue_command(cmd_t c, logic [KEY_W-1:0] k, logic typed,
                                 status_t st, int n);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = k;
        s_tuser  = c;
        do @(posedge aclk); while (!s_tready);
        table_apply(c, k);
        if (typed) begin
            replies_due.push_back(reply_of(st, k, n, 1'b1));
        end else begin
            foreach (fresh[i]) replies_due.push_back(fresh[i]);
        end
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    initial begin
        int   j;
        int   ph;
        int   n;
        int   roll;
        logic filling;
        cmd_t c;

        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_INSERT;
        aresetn   = 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        held_n    = 0;
        fails     = 0;
        cycles    = 0;
        filling   = 1'b1;

        // directed plan: empty table, extremes, fill to full, drain to empty
        plan.push_back(cmd_row(CMD_SEARCH, 32'h0000_0000, 1, 1'b1, ST_EMPTY, 0));
        plan.push_back(cmd_row(CMD_DUMP,   32'h5A5A_5A5A, 1, 1'b1, ST_EMPTY, 0));
        plan.push_back(cmd_row(CMD_DELETE, 32'h0000_0007, 1, 1'b1, ST_MISSING, 0));
        plan.push_back(cmd_row(CMD_INSERT, 32'h7FFF_FFFF, 1, 1'b1, ST_OK, 1));
        plan.push_back(cmd_row(CMD_INSERT, 32'h8000_0000, 1, 1'b1, ST_OK, 2));
        plan.push_back(cmd_row(CMD_INSERT, 32'h7FFF_FFFF, 1, 1'b1, ST_DUP, 2));
        plan.push_back(cmd_row(CMD_INSERT, 32'h0000_0000, 1, 1'b0, ST_OK, 0));
        plan.push_back(cmd_row(CMD_INSERT, 32'hFFFF_FFFF, 1, 1'b0, ST_OK, 0));
        plan.push_back(cmd_row(CMD_SEARCH, 32'h8000_0000, 1, 1'b1, ST_OK, 4));
        plan.push_back(cmd_row(CMD_SEARCH, 32'h0000_0005, 1, 1'b1, ST_MISSING, 4));
        plan.push_back(cmd_row(CMD_DUMP,   32'h0000_0000, 1, 1'b0, ST_OK, 0));
        plan.push_back(cmd_row(CMD_DELETE, 32'h0000_0000, 1, 1'b0, ST_OK, 0));
        plan.push_back(cmd_row(CMD_INSERT, 32'd100, 13, 1'b0, ST_OK, 0));
        plan.push_back(cmd_row(CMD_INSERT, 32'd5000, 1, 1'b1, ST_FULL, 16));
        plan.push_back(cmd_row(CMD_INSERT, 32'd106, 1, 1'b1, ST_DUP, 16));
        plan.push_back(cmd_row(CMD_SEARCH, 32'd112, 1, 1'b1, ST_OK, 16));
        plan.push_back(cmd_row(CMD_DUMP,   32'h0000_0000, 1, 1'b0, ST_OK, 0));
        plan.push_back(cmd_row(CMD_DELETE, 32'h7FFF_FFFF, 1, 1'b1, ST_OK, 15));
        plan.push_back(cmd_row(CMD_DELETE, 32'h8000_0000, 1, 1'b1, ST_OK, 14));
        plan.push_back(cmd_row(CMD_SEARCH, 32'h5555_5555, 1, 1'b1, ST_MISSING, 14));
        plan.push_back(cmd_row(CMD_DELETE, 32'h5555_5555, 1, 1'b1, ST_MISSING, 14));
        plan.push_back(cmd_row(CMD_DELETE, 32'd100, 13, 1'b0, ST_OK, 0));
        plan.push_back(cmd_row(CMD_DELETE, 32'hFFFF_FFFF, 1, 1'b1, ST_OK, 0));
        plan.push_back(cmd_row(CMD_DUMP,   32'hAAAA_AAAA, 1, 1'b1, ST_EMPTY, 0));

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed part
        foreach (plan[r]) begin
            for (j = 0; j < plan[r].reps; j++) begin
                issue_command(plan[r].cmd, plan[r].key + j, plan[r].typed,
                              plan[r].status, plan[r].count);
            end
        end

        // random runs: no idling, sender idle, receiver stall, both
        for (ph = 0; ph < 4; ph++) begin
            // hold off until the table has answered everything
            while (replies_due.size() != 0) @(posedge aclk);
            @(negedge aclk);
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 68; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 68; end
                default: begin idle_pct = 21; stall_pct = 21; end
            endcase
            for (n = 0; n < RANDOM_PER_PHASE; n++) begin
                // swing between filling and draining so full and empty recur
                if (held_n == CAP) filling = 1'b0;
                if (held_n == 0) filling = 1'b1;
                roll = $urandom_range(0, 99);
                if (roll < (filling ? 55 : 20))      c = CMD_INSERT;
                else if (roll < (filling ? 75 : 70)) c = CMD_DELETE;
                else if (roll < 92)                  c = CMD_SEARCH;
                else                                 c = CMD_DUMP;
                issue_command(c, pick_key(), 1'b0, ST_OK, 0);
            end
        end

        // drain, then let the block settle
        while (replies_due.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (fails == 0 && replies_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
